// File: rtl/fdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_pkg
// Shared constants and command types for the decimal format printer.
// ----------------------------------------------------------------------------
package fdp_pkg;

    // ASCII codes the block reacts to or produces
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // What the back end has to do with a queued request
    typedef enum logic [1:0] {
        KIND_PASS = 2'd0,
        KIND_DEC  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

endpackage

// File: rtl/fdp_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_ifs
// Valid/ready channel interfaces for format requests and printed characters.
// ----------------------------------------------------------------------------
interface fdp_in_if #(
    parameter int ARG_WIDTH = 32
);
    logic                        valid;
    logic                        ready;
    logic [7:0]                  format_char;
    logic signed [ARG_WIDTH-1:0] argument;

    modport source (output valid, output format_char, output argument, input ready);
    modport sink   (input valid, input format_char, input argument, output ready);
endinterface

interface fdp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       error;
    logic       last;

    modport source (output valid, output out_char, output error, output last, input ready);
    modport sink   (input valid, input out_char, input error, input last, output ready);
endinterface

// File: rtl/fdp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_front
// Accepts format requests, tracks a pending percent and the halt flag, and
// pushes classified commands into the queue.
// ----------------------------------------------------------------------------
module fdp_front #(
    parameter int ARG_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    fdp_in_if.sink                             i_in,
    input  logic                               i_q_full,
    output logic                               o_push,
    output logic [fdp_pkg::CMD_W+ARG_WIDTH-1:0] o_push_data
);

    logic         r_pct_pend;
    logic         r_halted;
    logic         accept;
    fdp_pkg::t_cmd cmd;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    // Classify the request
    always_comb begin
        cmd.ch   = i_in.format_char;
        cmd.kind = fdp_pkg::KIND_PASS;
        o_push   = 1'b0;
        if (accept && !r_halted) begin
            if (r_pct_pend) begin
                o_push   = 1'b1;
                cmd.kind = (i_in.format_char == fdp_pkg::CH_D) ? fdp_pkg::KIND_DEC
                                                              : fdp_pkg::KIND_ERR;
            end else if (i_in.format_char != fdp_pkg::CH_PERCENT) begin
                o_push = 1'b1;
            end
        end
    end

    assign o_push_data = {cmd, i_in.argument};

    // Hold percent and halt state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct_pend <= 1'b0;
            r_halted   <= 1'b0;
        end else if (accept && !r_halted) begin
            if (r_pct_pend) begin
                r_pct_pend <= 1'b0;
                if (i_in.format_char != fdp_pkg::CH_D) begin
                    r_halted <= 1'b1;
                end
            end else if (i_in.format_char == fdp_pkg::CH_PERCENT) begin
                r_pct_pend <= 1'b1;
            end
        end
    end

    // Halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag dropped without reset");

endmodule

// File: rtl/fdp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_queue
// Short FIFO that decouples the classifying front end from the printer.
// ----------------------------------------------------------------------------
module fdp_queue #(
    parameter int DATA_W = 42
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = (fdp_pkg::QUEUE_DEPTH > 1) ? $clog2(fdp_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(fdp_pkg::QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [fdp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(fdp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Write storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(fdp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(fdp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || do_pop))
        else $error("push into full queue");

endmodule

// File: rtl/fdp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_back
// Pops queued commands and prints them: pass-through, error, or decimal
// conversion via a shift-and-add-3 BCD converter, leading zeros skipped.
// ----------------------------------------------------------------------------
module fdp_back #(
    parameter int ARG_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  logic [fdp_pkg::CMD_W+ARG_WIDTH-1:0] i_q_data,
    output logic                                o_q_pop,
    fdp_out_if.source                           o_out
);

    localparam int MAX_DIGITS = ((ARG_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BCD_W      = 4 * MAX_DIGITS;
    localparam int CNT_W      = $clog2(ARG_WIDTH + 1);
    localparam int LEFT_W     = $clog2(MAX_DIGITS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [ARG_WIDTH-1:0] r_mag, n_mag;
    logic [BCD_W-1:0]     r_bcd, n_bcd;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [LEFT_W-1:0]    r_left, n_left;
    logic                 r_ov, n_ov;
    logic [7:0]           r_char, n_char;
    logic                 r_err, n_err;
    logic                 r_last, n_last;

    fdp_pkg::t_cmd        q_cmd;
    logic [ARG_WIDTH-1:0] q_arg;
    logic                 q_neg;
    logic                 out_free;
    logic [BCD_W-1:0]     bcd_adj;
    logic [3:0]           top_dig;

    assign q_cmd    = fdp_pkg::t_cmd'(i_q_data[fdp_pkg::CMD_W+ARG_WIDTH-1:ARG_WIDTH]);
    assign q_arg    = i_q_data[ARG_WIDTH-1:0];
    assign q_neg    = q_arg[ARG_WIDTH-1];
    assign out_free = !r_ov || o_out.ready;
    assign top_dig  = r_bcd[BCD_W-1 -: 4];

    // Add 3 to every BCD digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                           : r_bcd[4*i +: 4];
        end
    end

    // Sequence pop, conversion, zero skip and digit output
    always_comb begin
        n_state = r_state;
        n_mag   = r_mag;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_left  = r_left;
        n_ov    = r_ov && !o_out.ready;
        n_char  = r_char;
        n_err   = r_err;
        n_last  = r_last;
        o_q_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    unique case (q_cmd.kind)
                        fdp_pkg::KIND_DEC: begin
                            n_mag   = q_neg ? (~q_arg + 1'b1) : q_arg;
                            n_bcd   = '0;
                            n_cnt   = CNT_W'(ARG_WIDTH);
                            n_state = S_CONV;
                            if (q_neg) begin
                                n_ov   = 1'b1;
                                n_char = fdp_pkg::CH_MINUS;
                                n_err  = 1'b0;
                                n_last = 1'b0;
                            end
                        end
                        fdp_pkg::KIND_ERR: begin
                            n_ov   = 1'b1;
                            n_char = q_cmd.ch;
                            n_err  = 1'b1;
                            n_last = 1'b1;
                        end
                        default: begin
                            n_ov   = 1'b1;
                            n_char = q_cmd.ch;
                            n_err  = 1'b0;
                            n_last = 1'b1;
                        end
                    endcase
                end
            end
            S_CONV: begin
                n_bcd = {bcd_adj[BCD_W-2:0], r_mag[ARG_WIDTH-1]};
                n_mag = {r_mag[ARG_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_left  = LEFT_W'(MAX_DIGITS);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (top_dig == 4'd0 && r_left != LEFT_W'(1)) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_left = r_left - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov   = 1'b1;
                    n_char = fdp_pkg::CH_ZERO + {4'd0, top_dig};
                    n_err  = 1'b0;
                    n_last = (r_left == LEFT_W'(1));
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_left = r_left - 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_char <= n_char;
        r_err  <= n_err;
        r_last <= n_last;
    end

    assign o_out.valid    = r_ov;
    assign o_out.out_char = r_char;
    assign o_out.error    = r_err;
    assign o_out.last     = r_last;

    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_left != '0))
        else $error("digit output with no digits left");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_err) |-> r_last)
        else $error("error result not marked last");

endmodule

// File: rtl/format_decimal_printer_unit.sv
`timescale 1ns / 1ps
// A pass-through or error result is registered in the queue and then in the output
// register after its request is taken. Decimal: serial shift-and-add-3 BCD conversion
// of ARG_WIDTH bits, leading zeros skipped, then one digit per cycle while not stalled.
// Throughput: one plain character per cycle unless stalled; serial BCD sets the %d rate.
// Reset (synchronous, active low) clears the pending percent, halt flag, queue and output.
// ----------------------------------------------------------------------------
// format_decimal_printer_unit
// Streaming printf-style formatter: characters pass through, %d prints the
// argument in decimal ASCII, any other specifier reports an error and halts.
// ----------------------------------------------------------------------------
module format_decimal_printer_unit #(
    parameter int ARG_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fdp_in_if.sink    i_in,
    fdp_out_if.source o_out
);

    localparam int Q_W = fdp_pkg::CMD_W + ARG_WIDTH;

    logic           push;
    logic [Q_W-1:0] push_data;
    logic           q_full;
    logic           q_valid;
    logic [Q_W-1:0] q_data;
    logic           q_pop;

    // Classify incoming requests
    fdp_front #(.ARG_WIDTH(ARG_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // Decouple front and back
    fdp_queue #(.DATA_W(Q_W)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (q_pop),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    // Print commands
    fdp_back #(.ARG_WIDTH(ARG_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule
